[rtl/sumu_pkg.sv]
// ----------------------------------------------------------------------------
// sumu_pkg: shared types and constants for substring_match_upcase
// Register indexes, the default window size, the result tail record and the
// ASCII upper-case helper.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sumu_pkg;

  // Default maximum pattern length (also the window depth)
  localparam int unsigned PatternMaxDef = 8;

  // Configuration register map
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_PATTERN = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LENGTH  = 2'd1;

  // Fixed field widths
  localparam int unsigned PatW   = 64;
  localparam int unsigned PlenW  = 4;
  localparam int unsigned TotalW = 32;

  // End-of-text information carried with a batch of departing bytes
  typedef struct packed {
    logic              last;
    logic [TotalW-1:0] total;
  } sumu_tail_t;

  // ASCII a-z to A-Z, everything else unchanged
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7a) begin
      r = c - 8'h20;
    end
    return r;
  endfunction

endpackage

[rtl/sumu_if.sv]
// ----------------------------------------------------------------------------
// sumu_if: valid/ready channels of substring_match_upcase
// Text input channel, result channel and configuration write channel.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

// Text byte input
interface sumu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

// Result output
interface sumu_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        last_out;
  logic [31:0] match_total;

  modport source (output valid, output out_byte, output last_out, output match_total,
                  input ready);
  modport sink   (input valid, input out_byte, input last_out, input match_total,
                  output ready);
endinterface

// Configuration register writes
interface sumu_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [63:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/substring_match_upcase.sv]
// A result appears in the cycle after the text byte that releases it.
// Accepts one text byte per cycle while each byte releases at most one result
// and results are taken; a byte releasing more than one result (end of text,
// shorter pattern) holds the input while the result batch register drains.
// Reset: rst_ni clears the registers, the window fill, the count and the
// batch; the window bytes themselves are not reset.
// ----------------------------------------------------------------------------
// substring_match_upcase: streaming substring matcher with upper-casing
// Keeps the last pattern-length minus one text bytes, counts pattern matches and
// upper-cases matched bytes before they leave.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module substring_match_upcase import sumu_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PatternMaxDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  sumu_cfg_if.sink  cfg_req,
  sumu_in_if.sink   in_req,
  sumu_out_if.source out_req
);

  localparam int unsigned CntW = $clog2(PATTERN_MAX + 1);

  logic [PatW-1:0]   pattern_q;
  logic [PlenW-1:0]  plen_q;
  logic [7:0]        win_q [PATTERN_MAX];
  logic [7:0]        win_d [PATTERN_MAX];
  logic [CntW-1:0]   fill_q, fill_d;
  logic [TotalW-1:0] cnt_q, cnt_next;
  logic [CntW-1:0]   len;
  logic [7:0]        emit [PATTERN_MAX];
  logic [CntW-1:0]   emit_n;
  logic              match;
  logic              accept;
  sumu_tail_t        tail;

  // configuration writes
  assign cfg_req.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      plen_q    <= '0;
    end else if (cfg_req.valid) begin
      unique case (cfg_req.index)
        CFG_PATTERN: pattern_q <= cfg_req.data;
        CFG_LENGTH:  plen_q    <= cfg_req.data[PlenW-1:0];
        default:     ;
      endcase
    end
  end

  // effective pattern length, clamped to the window depth
  assign len = (plen_q > PlenW'(PATTERN_MAX)) ? CntW'(PATTERN_MAX) : CntW'(plen_q);

  sumu_step #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_step (
    .win_i       (win_q),
    .fill_i      (fill_q),
    .len_i       (len),
    .pattern_i   (pattern_q),
    .text_byte_i (in_req.text_byte),
    .last_i      (in_req.end_of_text),
    .win_o       (win_d),
    .fill_o      (fill_d),
    .emit_o      (emit),
    .emit_n_o    (emit_n),
    .match_o     (match)
  );

  assign accept = in_req.valid && in_req.ready;

  // saturating match count including this byte's match
  assign cnt_next   = (match && (cnt_q != '1)) ? cnt_q + 1'b1 : cnt_q;
  assign tail.last  = in_req.end_of_text;
  assign tail.total = cnt_next;

  // window fill and match count; both clear at end of text
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      cnt_q  <= '0;
    end else if (accept) begin
      fill_q <= fill_d;
      cnt_q  <= in_req.end_of_text ? '0 : cnt_next;
    end
  end

  // window bytes
  always_ff @(posedge clk_i) begin
    if (accept) begin
      win_q <= win_d;
    end
  end

  sumu_outq #(
    .PATTERN_MAX (PATTERN_MAX)
  ) u_outq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .load_bytes_i (emit),
    .load_n_i     (emit_n),
    .load_tail_i  (tail),
    .load_ready_o (in_req.ready),
    .valid_o      (out_req.valid),
    .ready_i      (out_req.ready),
    .byte_o       (out_req.out_byte),
    .last_o       (out_req.last_out),
    .total_o      (out_req.match_total)
  );

endmodule

[rtl/sumu_step.sv]
// ----------------------------------------------------------------------------
// sumu_step: one text byte through the window
// Appends the byte, compares the newest pattern-length bytes against the
// pattern, upper-cases them on a hit and splits off the departing bytes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sumu_step import sumu_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PatternMaxDef,
  localparam int unsigned CntW = $clog2(PATTERN_MAX + 1),
  localparam int unsigned IdxW = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1
) (
  input  logic [7:0]      win_i [PATTERN_MAX],
  input  logic [CntW-1:0] fill_i,
  input  logic [CntW-1:0] len_i,
  input  logic [PatW-1:0] pattern_i,
  input  logic [7:0]      text_byte_i,
  input  logic            last_i,
  output logic [7:0]      win_o [PATTERN_MAX],
  output logic [CntW-1:0] fill_o,
  output logic [7:0]      emit_o [PATTERN_MAX],
  output logic [CntW-1:0] emit_n_o,
  output logic            match_o
);

  logic [CntW-1:0] fill1;
  logic [CntW-1:0] keep;
  logic [CntW-1:0] n;
  logic [7:0]      app [PATTERN_MAX];
  logic [7:0]      upc [PATTERN_MAX];
  logic            in_win [PATTERN_MAX];
  logic [2:0]      pidx;
  logic [CntW:0]   sidx;
  logic            hit;

  always_comb begin
    fill1 = fill_i + 1'b1;

    // append the new byte after the pending ones
    for (int j = 0; j < PATTERN_MAX; j++) begin
      app[j] = (j < int'(fill_i)) ? win_i[j] : text_byte_i;
    end

    // compare the newest len bytes with the pattern
    hit  = (len_i != '0) && (fill1 >= len_i);
    pidx = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      in_win[j] = (j < int'(fill1)) && (j + int'(len_i) >= int'(fill1));
      pidx      = 3'(j + int'(len_i) - int'(fill1));
      if (in_win[j] && (app[j] != pattern_i[8*pidx +: 8])) begin
        hit = 1'b0;
      end
    end

    // upper-case the matched span
    for (int j = 0; j < PATTERN_MAX; j++) begin
      upc[j] = (hit && in_win[j]) ? to_upper(app[j]) : app[j];
    end

    // bytes no later match can reach leave, oldest first
    if (last_i) begin
      keep = '0;
    end else if (len_i != '0) begin
      keep = len_i - 1'b1;
    end else begin
      keep = '0;
    end
    n = (fill1 > keep) ? fill1 - keep : '0;

    // shift the remaining bytes down
    sidx = '0;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      sidx = (CntW + 1)'(j) + {1'b0, n};
      if (sidx < (CntW + 1)'(PATTERN_MAX)) begin
        win_o[j] = upc[sidx[IdxW-1:0]];
      end else begin
        win_o[j] = '0;
      end
      emit_o[j] = upc[j];
    end

    fill_o   = last_i ? '0 : fill1 - n;
    emit_n_o = n;
    match_o  = hit;
  end

endmodule

[rtl/sumu_outq.sv]
// ----------------------------------------------------------------------------
// sumu_outq: result batch register
// Holds the bytes departing on one text byte and hands them out one per cycle
// while ready_i is high; takes the next batch in the cycle the last one is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sumu_outq import sumu_pkg::*; #(
  parameter int unsigned PATTERN_MAX = PatternMaxDef,
  localparam int unsigned CntW = $clog2(PATTERN_MAX + 1)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  logic [7:0]        load_bytes_i [PATTERN_MAX],
  input  logic [CntW-1:0]   load_n_i,
  input  sumu_tail_t        load_tail_i,
  output logic              load_ready_o,
  output logic              valid_o,
  input  logic              ready_i,
  output logic [7:0]        byte_o,
  output logic              last_o,
  output logic [TotalW-1:0] total_o
);

  logic [7:0]      bat_q [PATTERN_MAX];
  logic [7:0]      bat_d [PATTERN_MAX];
  logic [CntW-1:0] rem_q, rem_d;
  sumu_tail_t      tail_q;
  logic            pop;
  logic            final_one;

  assign pop          = valid_o && ready_i;
  assign final_one    = (rem_q == CntW'(1));
  assign load_ready_o = (rem_q == '0) || (final_one && ready_i);

  // next batch contents: load a new batch or shift out the head
  always_comb begin
    rem_d = rem_q;
    bat_d = bat_q;
    if (load_i) begin
      rem_d = load_n_i;
      bat_d = load_bytes_i;
    end else if (pop) begin
      rem_d = rem_q - 1'b1;
      for (int j = 0; j + 1 < PATTERN_MAX; j++) begin
        bat_d[j] = bat_q[j+1];
      end
    end
  end

  // batch count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else begin
      rem_q <= rem_d;
    end
  end

  // batch payload
  always_ff @(posedge clk_i) begin
    bat_q <= bat_d;
    if (load_i) begin
      tail_q <= load_tail_i;
    end
  end

  assign valid_o = (rem_q != '0);
  assign byte_o  = bat_q[0];
  assign last_o  = final_one && tail_q.last;
  assign total_o = last_o ? tail_q.total : '0;

endmodule

[rtl/sumu_checker.sv]
// ----------------------------------------------------------------------------
// sumu_checker: port-level checks for substring_match_upcase
// Watches the text and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sumu_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_last_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        out_last_i,
  input logic [31:0] out_total_i
);

  // a pending result is held until taken
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before being taken");

  // a stalled result blocks new text
  a_stall_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i)
    else $error("text request taken while result stalled");

  // end of text always releases at least one result
  a_last_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_last_i |=> out_valid_i)
    else $error("end of text produced no result");

  // the count is shown only on the final result
  a_total_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> out_total_i == 32'd0)
    else $error("match count on a non-final result");

endmodule

bind substring_match_upcase sumu_checker u_sumu_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_req.valid),
  .in_ready_i  (in_req.ready),
  .in_last_i   (in_req.end_of_text),
  .out_valid_i (out_req.valid),
  .out_ready_i (out_req.ready),
  .out_last_i  (out_req.last_out),
  .out_total_i (out_req.match_total)
);
